// ===== sv/rhd_pkg.sv =====
// rhd_pkg.sv: shared types and constants for the rtp hevc depacketizer
`timescale 1ns / 1ps
`default_nettype none
package rhd_pkg;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        packet_first;
        logic [15:0] packet_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       unit_start;
        logic       run_last;
    } t_out_item;

    // emission command from the front parser to the output sequencer
    typedef struct packed {
        logic       start_code;   // emit 00 00 00 01 first
        logic       hdr_pair;     // emit hdr_a, hdr_b
        logic [7:0] hdr_a;
        logic [7:0] hdr_b;
        logic       data_en;      // emit data byte last
        logic [7:0] data;
    } t_cmd;

    localparam int unsigned CmdW = $bits(t_cmd);

    localparam logic [5:0] TypeAp   = 6'd48;
    localparam logic [5:0] TypeFu   = 6'd49;
    localparam logic [5:0] TypePaci = 6'd50;

    typedef enum logic [6:0] {
        M_HDR     = 7'b0000001,
        M_SINGLE  = 7'b0000010,
        M_AP_LEAD = 7'b0000100,
        M_AP_HEAD = 7'b0001000,
        M_AP_COPY = 7'b0010000,
        M_FU      = 7'b0100000,
        M_PACI    = 7'b1000000
    } t_mode;

endpackage
`default_nettype wire

// ===== sv/rhd_front.sv =====
// rhd_front.sv: payload header parser producing emission commands
`timescale 1ns / 1ps
`default_nettype none
module rhd_front #(
    parameter int LENGTH_BITS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_donl,
    input  wire                     i_valid,
    input  wire rhd_pkg::t_in_item  i_item,
    output logic                    o_take,
    output logic                    o_cmd_valid,
    output rhd_pkg::t_cmd           o_cmd,
    input  wire                     i_cmd_room
);
    localparam logic [LENGTH_BITS-1:0] MaxLen = {LENGTH_BITS{1'b1}};

    rhd_pkg::t_mode         r_mode, n_mode;
    logic [15:0]            r_pos, n_pos;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [15:0]            r_ubl, n_ubl;
    logic [7:0]             r_h1, n_h1, r_h2, n_h2, r_ext, n_ext;
    logic                   r_drop, n_drop;

    logic [LENGTH_BITS-1:0] len_c, rem0, after;
    logic                   drop0, act;
    logic [7:0]             b, c2, ctype_h1, dh1;
    logic [15:0]            pos0, size, after16;
    logic [8:0]             phs;
    logic [15:0]            ubl_dec;
    rhd_pkg::t_mode         mode0;

    assign o_take = i_cmd_room;
    assign b = i_item.payload_byte;

    // next-state and command decode for one payload byte
    always_comb begin
        logic [5:0] t;
        n_mode = r_mode; n_pos = r_pos; n_rem = r_rem; n_ubl = r_ubl;
        n_h1 = r_h1; n_h2 = r_h2; n_ext = r_ext; n_drop = r_drop;
        o_cmd = '0;
        o_cmd_valid = 1'b0;
        c2 = '0; ctype_h1 = '0; phs = '0; size = '0; dh1 = r_h1; ubl_dec = '0;
        t = '0;
        if ({16'd0, i_item.packet_length} > {{(32-LENGTH_BITS){1'b0}}, MaxLen})
            len_c = MaxLen;
        else
            len_c = i_item.packet_length[LENGTH_BITS-1:0];
        mode0 = r_mode; pos0 = r_pos; rem0 = r_rem; drop0 = r_drop;
        if (i_item.packet_first) begin
            mode0 = rhd_pkg::M_HDR; pos0 = '0; rem0 = len_c;
            n_ext = '0; n_ubl = '0; drop0 = (len_c < 2);
        end
        n_mode = mode0; n_pos = pos0; n_rem = rem0; n_drop = drop0;
        act = !drop0 && (rem0 != '0);
        after = rem0 - 1'b1;
        after16 = 16'(after);
        if (act) begin
            n_rem = after;
            o_cmd_valid = 1'b1;
            dh1 = r_h1;
            unique case (mode0)
                rhd_pkg::M_HDR: begin
                    if (pos0 == 16'd0) begin
                        n_h1 = b; n_pos = 16'd1;
                        dh1 = 8'h00;
                        o_cmd_valid = 1'b0;
                    end else begin
                        n_h2 = b;
                        dh1 = r_h1;
                    end
                end
                rhd_pkg::M_SINGLE: begin
                    o_cmd.data_en = !(i_donl && pos0 < 16'd4);
                    o_cmd.data = b;
                    if (pos0 != 16'hFFFF) n_pos = pos0 + 16'd1;
                end
                rhd_pkg::M_AP_LEAD: begin
                    n_mode = rhd_pkg::M_AP_HEAD; n_pos = '0;
                end
                rhd_pkg::M_AP_HEAD: begin
                    if (pos0 == 16'd0 && after16 < (i_donl ? 16'd3 : 16'd2)) begin
                        n_drop = 1'b1;
                    end else if (i_donl && pos0 == 16'd0) begin
                        n_pos = 16'd1;
                    end else if ((i_donl ? pos0 - 16'd1 : pos0) == 16'd0) begin
                        n_ubl = {b, 8'h00};
                        if (pos0 != 16'hFFFF) n_pos = pos0 + 16'd1;
                    end else begin
                        size = r_ubl | {8'h00, b};
                        if (size > after16) begin
                            n_drop = 1'b1;
                        end else begin
                            o_cmd.start_code = 1'b1;
                            n_ubl = size; n_pos = '0;
                            n_mode = (size != 16'd0) ? rhd_pkg::M_AP_COPY
                                                     : rhd_pkg::M_AP_HEAD;
                        end
                    end
                end
                rhd_pkg::M_AP_COPY: begin
                    o_cmd.data_en = 1'b1; o_cmd.data = b;
                    ubl_dec = (r_ubl != 16'd0) ? r_ubl - 16'd1 : r_ubl;
                    n_ubl = ubl_dec;
                    if (ubl_dec == 16'd0) begin
                        n_mode = rhd_pkg::M_AP_HEAD; n_pos = '0;
                    end
                end
                rhd_pkg::M_FU: begin
                    if (pos0 == 16'd2) begin
                        if (b[7]) begin
                            o_cmd.start_code = 1'b1; o_cmd.hdr_pair = 1'b1;
                            o_cmd.hdr_a = {1'b0, b[5:0], r_h1[0]};
                            o_cmd.hdr_b = r_h2;
                        end
                    end else if (pos0 >= (i_donl ? 16'd5 : 16'd3)) begin
                        o_cmd.data_en = 1'b1; o_cmd.data = b;
                    end
                    if (pos0 != 16'hFFFF) n_pos = pos0 + 16'd1;
                end
                rhd_pkg::M_PACI: begin
                    if (pos0 == 16'd2) begin
                        n_ubl = {8'h00, b}; n_pos = 16'd3;
                    end else if (pos0 == 16'd3) begin
                        c2 = r_ubl[7:0];
                        phs = {1'b0, c2[0], 3'b000, b[7:4]};
                        if (b[0] || {7'd0, phs} >= after16) begin
                            n_drop = 1'b1;
                        end else begin
                            ctype_h1 = (r_h1 & 8'h81) | {1'b0, c2[6:1], 1'b0};
                            n_h1 = ctype_h1;
                            n_ext = phs[7:0];
                            n_pos = 16'd4;
                        end
                    end else begin
                        n_ext = (r_ext != 8'd0) ? r_ext - 8'd1 : r_ext;
                        if (pos0 != 16'hFFFF) n_pos = pos0 + 16'd1;
                    end
                end
                default: n_drop = 1'b1;
            endcase
            // dispatch on second header byte, or when the paci extension ends or is empty
            if ((mode0 == rhd_pkg::M_HDR && pos0 != 16'd0)
                || (mode0 == rhd_pkg::M_PACI && pos0 == 16'd3 && !n_drop
                    && phs == 9'd0)
                || (mode0 == rhd_pkg::M_PACI && pos0 != 16'd2 && pos0 != 16'd3
                    && n_ext == 8'd0)) begin
                dh1 = (mode0 == rhd_pkg::M_PACI && pos0 == 16'd3) ? ctype_h1 : r_h1;
                t = dh1[6:1];
                n_pos = 16'd2;
                if (t == rhd_pkg::TypeAp) begin
                    if (i_donl && after16 < 16'd4) n_drop = 1'b1;
                    else begin
                        n_mode = i_donl ? rhd_pkg::M_AP_LEAD : rhd_pkg::M_AP_HEAD;
                        n_pos = '0;
                    end
                end else if (t == rhd_pkg::TypeFu) begin
                    if ({1'b0, after16} + 17'd2 < (i_donl ? 17'd6 : 17'd4))
                        n_drop = 1'b1;
                    else n_mode = rhd_pkg::M_FU;
                end else if (t == rhd_pkg::TypePaci) begin
                    if ({1'b0, after16} + 17'd2 < 17'd5) n_drop = 1'b1;
                    else n_mode = rhd_pkg::M_PACI;
                end else begin
                    if (i_donl && {1'b0, after16} + 17'd2 < 17'd4) n_drop = 1'b1;
                    else begin
                        o_cmd.start_code = 1'b1; o_cmd.hdr_pair = 1'b1;
                        o_cmd.hdr_a = dh1;
                        o_cmd.hdr_b = (mode0 == rhd_pkg::M_HDR) ? b : r_h2;
                        n_mode = rhd_pkg::M_SINGLE;
                    end
                end
            end
        end
        if (!(o_cmd.start_code || o_cmd.hdr_pair || o_cmd.data_en))
            o_cmd_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rhd_pkg::M_HDR; r_pos <= '0; r_rem <= '0; r_ubl <= '0;
            r_h1 <= '0; r_h2 <= '0; r_ext <= '0; r_drop <= 1'b0;
        end else if (i_valid && o_take) begin
            r_mode <= n_mode; r_pos <= n_pos; r_rem <= n_rem; r_ubl <= n_ubl;
            r_h1 <= n_h1; r_h2 <= n_h2; r_ext <= n_ext; r_drop <= n_drop;
        end
    end
endmodule
`default_nettype wire

// ===== sv/rhd_back.sv =====
// rhd_back.sv: command queue and output byte sequencer
`timescale 1ns / 1ps
`default_nettype none
module rhd_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  wire rhd_pkg::t_cmd      i_cmd,
    output logic                    o_room,
    output logic                    o_valid,
    output rhd_pkg::t_out_item      o_item,
    input  wire                     i_stall
);
    rhd_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [2:0]    r_step;   // byte index within current command

    rhd_pkg::t_cmd head;
    logic [2:0]    first_step, last_step, nxt_step;
    logic          pop, fire;

    assign head = r_q[r_rp];
    assign o_room = (r_cnt != 2'd2) || pop;

    always_comb begin
        first_step = head.start_code ? 3'd0 : (head.hdr_pair ? 3'd4 : 3'd6);
        last_step  = head.data_en ? 3'd6 : 3'd5;
        if (!head.hdr_pair && !head.data_en) last_step = 3'd3;
        nxt_step = r_step + 3'd1;
        if (nxt_step == 3'd4 && !head.hdr_pair) nxt_step = 3'd6;
        o_valid = (r_cnt != 2'd0);
        o_item.unit_start = (r_step == 3'd0);
        o_item.run_last = (r_step == last_step);
        case (r_step)
            3'd3:    o_item.stream_byte = 8'h01;
            3'd4:    o_item.stream_byte = head.hdr_a;
            3'd5:    o_item.stream_byte = head.hdr_b;
            3'd6:    o_item.stream_byte = head.data;
            default: o_item.stream_byte = 8'h00;
        endcase
        fire = o_valid && !i_stall;
        pop = fire && o_item.run_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_room) r_q[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_step <= '0;
        end else begin
            if (i_push && o_room) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push && o_room} - {1'b0, pop};
            if (pop) begin
                if (r_cnt == 2'd2)
                    r_step <= r_q[~r_rp].start_code ? 3'd0
                            : (r_q[~r_rp].hdr_pair ? 3'd4 : 3'd6);
                else
                    r_step <= i_cmd.start_code ? 3'd0 : (i_cmd.hdr_pair ? 3'd4 : 3'd6);
            end else if (fire) begin
                r_step <= nxt_step;
            end else if (r_cnt == 2'd0) begin
                r_step <= i_cmd.start_code ? 3'd0 : (i_cmd.hdr_pair ? 3'd4 : 3'd6);
            end
        end
    end

`ifndef SYNTH
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_step >= first_step && r_step <= last_step))
        else $error("step out of command range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |-> !o_room) else $error("room while full");
`endif
endmodule
`default_nettype wire

// ===== sv/rtp_hevc_depacketizer.sv =====
// rtp_hevc_depacketizer.sv: top level of the rtp hevc to annex b depacketizer
// throughput: one payload byte per cycle while o_stall is low; a byte yields up to 6 output bytes
// at one per cycle unless i_stall holds them, so input stalls while start codes and headers drain
// the two-entry command queue sets how far the parser runs ahead of output
// reset: i_rst_n synchronous active low, clears parser state, queue and register
`timescale 1ns / 1ps
`default_nettype none
module rtp_hevc_depacketizer #(
    parameter int LENGTH_BITS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire                     i_cfg_data,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire rhd_pkg::t_in_item  i_item,
    output logic                    o_valid,
    input  wire                     i_stall,
    output rhd_pkg::t_out_item      o_item
);
    logic          r_donl;
    logic          take, cmd_valid, room;
    rhd_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;
    // stall input whenever the command queue has no free entry
    assign o_stall = !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_donl <= 1'b0;
        else if (i_cfg_valid) r_donl <= i_cfg_data;
    end

    // front: parse payload bytes, issue one command per byte that emits
    rhd_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_donl(r_donl),
        .i_valid(i_valid), .i_item(i_item), .o_take(take),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_room(room)
    );

    // back: queue commands and serialize them into stream bytes
    rhd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_valid && take && cmd_valid), .i_cmd(cmd), .o_room(room),
        .o_valid(o_valid), .o_item(o_item), .i_stall(i_stall)
    );
endmodule
`default_nettype wire
